// ===== hw/rtl/hbs_pkg.sv =====
// Shared types and constants for the bucketed hash set.
package hbs_pkg;

  // Default sizing, used as the parameter defaults of every module
  localparam int NUM_BUCKETS_DEF = 1024;
  localparam int WAYS_DEF        = 4;
  localparam int KEY_BITS_DEF    = 20;

  // Fixed width of the key field on the command port
  localparam int KEY_W = 20;

  // Bucket hash multiplier and its width
  localparam int HASH_MULT = 1031;
  localparam int MULT_BITS = 11;

  // Command codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  // One command beat
  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] key;
  } item_t;

  // One result beat
  typedef struct packed {
    logic present;
    logic bucket_full;
  } result_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  // Decision from the row compare, handed to the controller
  typedef struct packed {
    logic hit;
    logic full;
    logic key_we;
    logic valid_we;
  } upd_t;

endpackage

// ===== hw/rtl/hbs_hash.sv =====
// Key normalization and bucket hash: (key * 1031) mod NUM_BUCKETS.
module hbs_hash #(
  parameter int NUM_BUCKETS = hbs_pkg::NUM_BUCKETS_DEF,
  parameter int KEY_BITS    = hbs_pkg::KEY_BITS_DEF
) (
  input  logic [hbs_pkg::KEY_W-1:0]       key,
  output logic [KEY_BITS-1:0]             key_norm,
  output logic [$clog2(NUM_BUCKETS)-1:0]  bucket
);

  localparam int BB     = $clog2(NUM_BUCKETS);
  localparam int PROD_W = KEY_BITS + hbs_pkg::MULT_BITS;

  logic [KEY_BITS+hbs_pkg::KEY_W-1:0] key_wide;
  logic [PROD_W-1:0]                  prod;

  // Keep the low KEY_BITS bits, zero-extending a narrower field
  assign key_wide = {{KEY_BITS{1'b0}}, key};
  assign key_norm = key_wide[KEY_BITS-1:0];

  // Power-of-two bucket count: the modulo is the low bits of the product
  assign prod   = PROD_W'(key_norm) * PROD_W'(hbs_pkg::HASH_MULT);
  assign bucket = prod[BB-1:0];

endmodule

// ===== hw/rtl/hbs_table.sv =====
// Bucket table: one row of keys and one row of valid marks per bucket.
module hbs_table #(
  parameter int NUM_BUCKETS = hbs_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = hbs_pkg::WAYS_DEF,
  parameter int KEY_BITS    = hbs_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_BUCKETS)-1:0] rd_addr,
  output logic [WAYS*KEY_BITS-1:0]       rd_keys,
  output logic [WAYS-1:0]                rd_valid,
  input  logic [$clog2(NUM_BUCKETS)-1:0] wr_addr,
  input  logic                           key_we,
  input  logic [WAYS*KEY_BITS-1:0]       wr_keys,
  input  logic                           valid_we,
  input  logic [WAYS-1:0]                wr_valid
);

  logic [WAYS*KEY_BITS-1:0] key_mem   [NUM_BUCKETS];
  logic [WAYS-1:0]          valid_mem [NUM_BUCKETS];

  // Key rows: write on update, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_keys;
    end
    if (rd_en) begin
      rd_keys <= key_mem[rd_addr];
    end
  end

  // Valid rows: cleared by the sweep after reset, registered read
  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[wr_addr] <= wr_valid;
    end
    if (rd_en) begin
      rd_valid <= valid_mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/hbs_match.sv =====
// Row compare across all ways and the modified row for write-back.
module hbs_match #(
  parameter int WAYS     = hbs_pkg::WAYS_DEF,
  parameter int KEY_BITS = hbs_pkg::KEY_BITS_DEF
) (
  input  hbs_pkg::cmd_t             command,
  input  logic [KEY_BITS-1:0]       key,
  input  logic [WAYS*KEY_BITS-1:0]  row_keys,
  input  logic [WAYS-1:0]           row_valid,
  output hbs_pkg::upd_t             upd,
  output logic [WAYS*KEY_BITS-1:0]  new_keys,
  output logic [WAYS-1:0]           new_valid
);

  logic [WAYS-1:0] eq;
  logic [WAYS-1:0] free;
  logic [WAYS-1:0] free_oh;
  logic            hit;
  logic            has_free;

  // Compare every occupied way against the key
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      eq[w] = row_valid[w] && (row_keys[w*KEY_BITS +: KEY_BITS] == key);
    end
  end

  // Pick the lowest free way
  assign free     = ~row_valid;
  assign free_oh  = free & (~free + WAYS'(1));
  assign hit      = |eq;
  assign has_free = |free;

  // Insert the key into the chosen way, keep the rest
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_keys[w*KEY_BITS +: KEY_BITS] =
        free_oh[w] ? key : row_keys[w*KEY_BITS +: KEY_BITS];
    end
  end

  // Decide the update for this command
  always_comb begin
    upd.hit      = hit;
    upd.full     = 1'b0;
    upd.key_we   = 1'b0;
    upd.valid_we = 1'b0;
    new_valid    = row_valid;
    case (command)
      hbs_pkg::CMD_ADD: begin
        if (!hit) begin
          if (has_free) begin
            upd.key_we   = 1'b1;
            upd.valid_we = 1'b1;
            new_valid    = row_valid | free_oh;
          end else begin
            upd.full = 1'b1;
          end
        end
      end
      hbs_pkg::CMD_REMOVE: begin
        upd.valid_we = hit;
        new_valid    = row_valid & ~eq;
      end
      default: begin
        upd.valid_we = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bucketed_hash_set_top.sv =====
// Top level of the bucketed hash set: controller, hash, table and compare.
//
//   channel   direction  handshake            payload
//   command   in         start & !busy        item   (command, key)
//   result    out        done, one cycle      result (present, bucket_full)
//
// A command passes through ST_READ, which reads its bucket row from the
// table memory, and ST_MODIFY, which compares all ways and writes the row back. The next
// command is taken in the write-back cycle. The result strobe is registered, rises in the
// cycle after the write-back and cannot be stalled by the receiver.
// After reset the valid rows are swept clear, one bucket a cycle, so busy
// stays high until every bucket has been cleared.
module bucketed_hash_set_top #(
  parameter int NUM_BUCKETS = hbs_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = hbs_pkg::WAYS_DEF,
  parameter int KEY_BITS    = hbs_pkg::KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hbs_pkg::item_t   item,
  output logic             done,
  output hbs_pkg::result_t result
);

  localparam int BB = $clog2(NUM_BUCKETS);

  hbs_pkg::state_t          state;
  hbs_pkg::state_t          state_next;
  logic [BB-1:0]            clr_idx;
  logic                     accept;

  hbs_pkg::cmd_t            cmd_q;
  logic [KEY_BITS-1:0]      key_q;
  logic [BB-1:0]            bucket_q;

  logic [KEY_BITS-1:0]      key_norm;
  logic [BB-1:0]            bucket;

  logic                     rd_en;
  logic [BB-1:0]            wr_addr;
  logic                     key_we;
  logic                     valid_we;
  logic [WAYS-1:0]          wr_valid;
  logic [WAYS*KEY_BITS-1:0] rd_keys;
  logic [WAYS-1:0]          rd_valid;

  hbs_pkg::upd_t            upd;
  logic [WAYS*KEY_BITS-1:0] new_keys;
  logic [WAYS-1:0]          new_valid;

  // Hash the incoming key
  hbs_hash #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_BITS    (KEY_BITS)
  ) u_hash (
    .key      (item.key),
    .key_norm (key_norm),
    .bucket   (bucket)
  );

  // Bucket rows
  hbs_table #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS)
  ) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (bucket_q),
    .rd_keys  (rd_keys),
    .rd_valid (rd_valid),
    .wr_addr  (wr_addr),
    .key_we   (key_we),
    .wr_keys  (new_keys),
    .valid_we (valid_we),
    .wr_valid (wr_valid)
  );

  // Compare the row and build the write-back
  hbs_match #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .command   (cmd_q),
    .key       (key_q),
    .row_keys  (rd_keys),
    .row_valid (rd_valid),
    .upd       (upd),
    .new_keys  (new_keys),
    .new_valid (new_valid)
  );

  assign busy   = (state == hbs_pkg::ST_CLEAR) || (state == hbs_pkg::ST_READ);
  assign accept = start && !busy;

  // State register and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hbs_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == hbs_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + BB'(1);
      end
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_addr    = bucket_q;
    key_we     = 1'b0;
    valid_we   = 1'b0;
    wr_valid   = new_valid;
    unique case (state)
      hbs_pkg::ST_CLEAR: begin
        wr_addr  = clr_idx;
        valid_we = 1'b1;
        wr_valid = '0;
        if (clr_idx == BB'(NUM_BUCKETS - 1)) begin
          state_next = hbs_pkg::ST_IDLE;
        end
      end
      hbs_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = hbs_pkg::ST_READ;
        end
      end
      hbs_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = hbs_pkg::ST_MODIFY;
      end
      hbs_pkg::ST_MODIFY: begin
        key_we     = upd.key_we;
        valid_we   = upd.valid_we;
        state_next = accept ? hbs_pkg::ST_READ : hbs_pkg::ST_IDLE;
      end
      default: begin
        state_next = hbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= item.command;
      key_q    <= key_norm;
      bucket_q <= bucket;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == hbs_pkg::ST_MODIFY);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == hbs_pkg::ST_MODIFY) begin
      result.present     <= upd.hit;
      result.bucket_full <= upd.full;
    end
  end

  // A result beat always follows a write-back cycle
  a_done_after_modify: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == hbs_pkg::ST_MODIFY)
    else $error("result strobe without a preceding write-back cycle");

  // A rejected add never reports the key as present
  a_full_not_present: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.present && result.bucket_full))
    else $error("bucket_full reported together with present");

  // An accepted command reads its row next
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == hbs_pkg::ST_READ)
    else $error("accepted command did not start a row read");

  // Only an add writes key rows, and only into a free way
  a_key_write_add: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (cmd_q == hbs_pkg::CMD_ADD) && !upd.hit && valid_we)
    else $error("key row written outside an accepted add");

endmodule
